// ===== rtl/siq_pkg.sv =====
// Shared types, constants and codes for the sensor input qualifier.
package siq_pkg;

    localparam int FILTER_TIME_DEF  = 16;
    localparam int FILTER_SCALE_DEF = 16;
    localparam int LADDER_MAX       = 6;
    localparam int LADDER_SLOTS     = 6;

    localparam int ADC_W      = 10;
    localparam int VAL_W      = 3;
    localparam int TIME_W     = 32;
    localparam int DEB_W      = 8;
    localparam int ACC_W      = 16;
    localparam int LEVEL_W    = 10;
    localparam int EDGE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LADDER_SLOTS * ADC_W;

    localparam logic [ADC_W-1:0] THRESHOLD_RST = 10'd512;
    localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 8'd25;

    typedef enum logic [2:0] {
        MODE_DEFAULT     = 3'd0,
        MODE_FORCE_ON    = 3'd1,
        MODE_FORCE_OFF   = 3'd2,
        MODE_ACTIVE_LOW  = 3'd3,
        MODE_ACTIVE_HIGH = 3'd4,
        MODE_LOW_PULLUP  = 3'd5,
        MODE_HIGH_PULLUP = 3'd6,
        MODE_LADDER      = 3'd7
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_NORMAL   = 3'd0,
        CFG_MODE_OVERRIDE = 3'd1,
        CFG_ANALOG_ENABLE = 3'd2,
        CFG_THRESHOLD     = 3'd3,
        CFG_HYSTERESIS    = 3'd4,
        CFG_DEBOUNCE_MS   = 3'd5,
        CFG_LADDER_COUNT  = 3'd6,
        CFG_LADDER_LEVELS = 3'd7
    } cfg_reg_t;

    typedef enum logic [EDGE_W-1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_t;

    typedef struct packed {
        mode_t                  mode_normal;
        mode_t                  mode_override;
        logic                   analog_enable;
        logic [ADC_W-1:0]       threshold;
        logic [ADC_W-1:0]       hysteresis;
        logic [DEB_W-1:0]       debounce_ms;
        logic [VAL_W-1:0]       ladder_count;
        logic [CFG_DATA_W-1:0]  ladder_levels;
    } cfg_t;

    typedef struct packed {
        logic               pin_level;
        logic [ADC_W-1:0]   adc_sample;
        logic [TIME_W-1:0]  now_ms;
    } sample_t;

    typedef struct packed {
        logic [VAL_W-1:0]   raw_value;
        logic [VAL_W-1:0]   stable_value;
        edge_t              edge_event;
        logic [ACC_W-1:0]   filter_accum;
    } result_t;

endpackage

// ===== rtl/siq_cfg_regs.sv =====
// Configuration register bank with pre-scaled threshold and hysteresis.
module siq_cfg_regs #(
    parameter int FILTER_SCALE = siq_pkg::FILTER_SCALE_DEF,
    parameter int SCALED_W     = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [siq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [siq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output siq_pkg::cfg_t                   cfg,
    output logic [SCALED_W-1:0]             thr_scaled,
    output logic [SCALED_W-1:0]             hys_scaled
);

    siq_pkg::cfg_t         cfg_reg;
    logic [SCALED_W-1:0]   thr_scaled_reg;
    logic [SCALED_W-1:0]   hys_scaled_reg;

    // The scaled copies let the compare run directly on the accumulator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_normal   <= siq_pkg::MODE_DEFAULT;
            cfg_reg.mode_override <= siq_pkg::MODE_DEFAULT;
            cfg_reg.analog_enable <= 1'b0;
            cfg_reg.threshold     <= siq_pkg::THRESHOLD_RST;
            cfg_reg.hysteresis    <= '0;
            cfg_reg.debounce_ms   <= siq_pkg::DEBOUNCE_RST;
            cfg_reg.ladder_count  <= '0;
            cfg_reg.ladder_levels <= '0;
            thr_scaled_reg        <= SCALED_W'(siq_pkg::THRESHOLD_RST * FILTER_SCALE);
            hys_scaled_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (siq_pkg::cfg_reg_t'(cfg_index))
                siq_pkg::CFG_MODE_NORMAL: begin
                    cfg_reg.mode_normal <= siq_pkg::mode_t'(cfg_wdata[2:0]);
                end
                siq_pkg::CFG_MODE_OVERRIDE: begin
                    cfg_reg.mode_override <= siq_pkg::mode_t'(cfg_wdata[2:0]);
                end
                siq_pkg::CFG_ANALOG_ENABLE: begin
                    cfg_reg.analog_enable <= cfg_wdata[0];
                end
                siq_pkg::CFG_THRESHOLD: begin
                    cfg_reg.threshold <= cfg_wdata[siq_pkg::ADC_W-1:0];
                    thr_scaled_reg    <= SCALED_W'(cfg_wdata[siq_pkg::ADC_W-1:0] * FILTER_SCALE);
                end
                siq_pkg::CFG_HYSTERESIS: begin
                    cfg_reg.hysteresis <= cfg_wdata[siq_pkg::ADC_W-1:0];
                    hys_scaled_reg     <= SCALED_W'(cfg_wdata[siq_pkg::ADC_W-1:0] * FILTER_SCALE);
                end
                siq_pkg::CFG_DEBOUNCE_MS: begin
                    cfg_reg.debounce_ms <= cfg_wdata[siq_pkg::DEB_W-1:0];
                end
                siq_pkg::CFG_LADDER_COUNT: begin
                    cfg_reg.ladder_count <= cfg_wdata[siq_pkg::VAL_W-1:0];
                end
                siq_pkg::CFG_LADDER_LEVELS: begin
                    cfg_reg.ladder_levels <= cfg_wdata;
                end
            endcase
        end
    end

    assign cfg        = cfg_reg;
    assign thr_scaled = thr_scaled_reg;
    assign hys_scaled = hys_scaled_reg;

endmodule

// ===== rtl/siq_filter.sv =====
// First-order IIR filter update using a reciprocal multiply for the divide.
module siq_filter #(
    parameter int FILTER_TIME  = siq_pkg::FILTER_TIME_DEF,
    parameter int FILTER_SCALE = siq_pkg::FILTER_SCALE_DEF
) (
    input  logic [siq_pkg::ACC_W-1:0]  acc,
    input  logic [siq_pkg::ADC_W-1:0]  sample,
    output logic [siq_pkg::ACC_W-1:0]  acc_next
);

    // acc*(T-1) + c equals acc*T + (c - acc), so the new value is acc plus the
    // floor of (c - acc)/T. A bias that is a multiple of T keeps the dividend
    // positive, and the bias quotient is taken back off afterwards.
    localparam int     AccSpan    = 1 << siq_pkg::ACC_W;
    localparam int     CMax       = ((1 << siq_pkg::ADC_W) - 1) * FILTER_SCALE
                                    + FILTER_SCALE / 2;
    localparam int     BiasQ      = (AccSpan + FILTER_TIME - 1) / FILTER_TIME;
    localparam int     Bias       = BiasQ * FILTER_TIME;
    localparam int     XW         = $clog2(CMax + Bias + 1);
    localparam int     TW         = $clog2(FILTER_TIME);
    localparam int     RecipShift = XW + TW;
    localparam longint Recip      = ((longint'(1) << RecipShift) + FILTER_TIME - 1)
                                    / FILTER_TIME;
    localparam int     RW         = $clog2(Recip + 1);
    localparam int     PW         = XW + RW;

    logic [XW-1:0] dividend;
    logic [PW-1:0] product;
    logic [XW-1:0] quotient;
    logic [XW-1:0] sum;

    assign dividend = XW'(sample) * XW'(FILTER_SCALE)
                    + XW'(FILTER_SCALE / 2 + Bias) - XW'(acc);
    // The rounded-up reciprocal is exact for every dividend below 2**XW.
    assign product  = PW'(dividend) * PW'(Recip);
    assign quotient = XW'(product >> RecipShift);
    assign sum      = XW'(acc) + quotient - XW'(BiasQ);
    assign acc_next = sum[siq_pkg::ACC_W-1:0];

endmodule

// ===== rtl/siq_qualify.sv =====
// Mode selection, threshold and ladder classification, debounce and state.
module siq_qualify #(
    parameter int FILTER_TIME  = siq_pkg::FILTER_TIME_DEF,
    parameter int FILTER_SCALE = siq_pkg::FILTER_SCALE_DEF,
    parameter int SCALED_W     = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  siq_pkg::sample_t      sample,
    input  siq_pkg::cfg_t         cfg,
    input  logic [SCALED_W-1:0]   thr_scaled,
    input  logic [SCALED_W-1:0]   hys_scaled,
    output siq_pkg::result_t      result_next
);

    localparam int CmpW = (SCALED_W > siq_pkg::ACC_W) ? SCALED_W : siq_pkg::ACC_W;
    localparam int VW   = siq_pkg::VAL_W;

    logic [siq_pkg::ACC_W-1:0]   acc_reg;
    logic [VW-1:0]               prev_raw_reg;
    logic [VW-1:0]               accepted_reg;
    logic [siq_pkg::TIME_W-1:0]  last_change_reg;

    siq_pkg::mode_t              mode;
    logic                        filter_run;
    logic [siq_pkg::ACC_W-1:0]   acc_filt;
    logic [siq_pkg::ACC_W-1:0]   acc_now;
    logic                        neg_bound;
    logic [SCALED_W-1:0]         low_scaled;
    logic                        below_thr;
    logic                        below_low;
    logic [VW-1:0]               ladder_used;
    logic [VW-1:0]               ladder_val;
    logic [VW-1:0]               raw;
    logic [siq_pkg::TIME_W-1:0]  hold_end;
    logic                        changed;
    logic                        expired;
    logic [VW-1:0]               accepted_next;
    siq_pkg::edge_t              edge_next;

    assign mode = (cfg.mode_override != siq_pkg::MODE_DEFAULT) ?
                  cfg.mode_override : cfg.mode_normal;

    assign filter_run = cfg.analog_enable
                     && (mode != siq_pkg::MODE_FORCE_ON)
                     && (mode != siq_pkg::MODE_FORCE_OFF);

    siq_filter #(
        .FILTER_TIME  (FILTER_TIME),
        .FILTER_SCALE (FILTER_SCALE)
    ) u_filter (
        .acc      (acc_reg),
        .sample   (sample.adc_sample),
        .acc_next (acc_filt)
    );

    assign acc_now = filter_run ? acc_filt : acc_reg;

    // Comparing the accumulator with bound*scale is the same as comparing
    // the truncated level with the bound.
    assign neg_bound  = cfg.hysteresis > cfg.threshold;
    assign low_scaled = thr_scaled - hys_scaled;
    assign below_thr  = CmpW'(acc_now) < CmpW'(thr_scaled);
    assign below_low  = CmpW'(acc_now) < CmpW'(low_scaled);

    assign ladder_used = (cfg.ladder_count > VW'(siq_pkg::LADDER_MAX)) ?
                         VW'(siq_pkg::LADDER_MAX) : cfg.ladder_count;

    // Walk from the top level down so the lowest matching level wins.
    always_comb begin
        ladder_val = '0;
        for (int k = siq_pkg::LADDER_SLOTS; k >= 1; k--) begin
            if ((k <= int'(ladder_used)) && (sample.adc_sample <
                cfg.ladder_levels[siq_pkg::ADC_W*(k-1) +: siq_pkg::ADC_W])) begin
                ladder_val = VW'(k);
            end
        end
    end

    always_comb begin
        raw = '0;
        if (mode == siq_pkg::MODE_FORCE_ON) begin
            raw = VW'(1);
        end else if (mode == siq_pkg::MODE_FORCE_OFF) begin
            raw = '0;
        end else if (!cfg.analog_enable) begin
            raw = VW'(sample.pin_level ^ ((mode == siq_pkg::MODE_ACTIVE_LOW)
                                       || (mode == siq_pkg::MODE_LOW_PULLUP)));
        end else begin
            case (mode)
                siq_pkg::MODE_ACTIVE_LOW: begin
                    if (prev_raw_reg != '0) begin
                        raw = VW'(below_thr);
                    end else begin
                        raw = VW'(neg_bound || below_low);
                    end
                end
                siq_pkg::MODE_ACTIVE_HIGH: begin
                    if (prev_raw_reg != '0) begin
                        raw = VW'(!neg_bound && !below_low);
                    end else begin
                        raw = VW'(!below_thr);
                    end
                end
                siq_pkg::MODE_LADDER: begin
                    raw = ladder_val;
                end
                default: begin
                    raw = '0;
                end
            endcase
        end
    end

    assign hold_end = last_change_reg + siq_pkg::TIME_W'(cfg.debounce_ms);
    assign changed  = raw != prev_raw_reg;
    assign expired  = hold_end < sample.now_ms;

    always_comb begin
        accepted_next = accepted_reg;
        edge_next     = siq_pkg::EDGE_NONE;
        if (!changed && expired && (accepted_reg != raw)) begin
            accepted_next = raw;
            edge_next     = (raw != '0) ? siq_pkg::EDGE_RISE : siq_pkg::EDGE_FALL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= '0;
            prev_raw_reg    <= '0;
            accepted_reg    <= '0;
            last_change_reg <= '0;
        end else if (step) begin
            acc_reg      <= acc_now;
            prev_raw_reg <= raw;
            accepted_reg <= accepted_next;
            if (changed) begin
                last_change_reg <= sample.now_ms;
            end
        end
    end

    assign result_next.raw_value    = raw;
    assign result_next.stable_value = accepted_next;
    assign result_next.edge_event   = edge_next;
    assign result_next.filter_accum = acc_now;

    a_state_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(accepted_reg) && $stable(prev_raw_reg) && $stable(acc_reg))
        else $error("qualifier state changed without a beat");

    a_acc_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !filter_run) |=> acc_reg == $past(acc_reg))
        else $error("filter accumulator moved while the filter was not selected");

    a_edge_settles: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && edge_next != siq_pkg::EDGE_NONE) |=> accepted_reg == prev_raw_reg)
        else $error("accepted value disagrees with raw value after an edge");

endmodule

// ===== rtl/sensor_input_qualifier_top.sv =====
// A beat accepted into the input register is qualified and stored in the result register,
// which drives the result ports.
// Throughput: one beat per cycle while the result side is not stalled; the state update is a single registered pass.
// The input register and the result register each take a new beat whenever
// the stage after them frees up, so stalls on the result side do not lose data.
// Reset (synchronous, active low) clears filter, debounce state and valid flags
// and loads the configuration registers with their default values.
module sensor_input_qualifier_top #(
    parameter int FILTER_TIME  = siq_pkg::FILTER_TIME_DEF,
    parameter int FILTER_SCALE = siq_pkg::FILTER_SCALE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_pin_level,
    input  logic [siq_pkg::ADC_W-1:0]       s_adc_sample,
    input  logic [siq_pkg::TIME_W-1:0]      s_now_ms,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [siq_pkg::VAL_W-1:0]       m_raw_value,
    output logic [siq_pkg::VAL_W-1:0]       m_stable_value,
    output logic [siq_pkg::EDGE_W-1:0]      m_edge_event,
    output logic [siq_pkg::LEVEL_W-1:0]     m_filtered_level,

    input  logic                            cfg_wr_en,
    input  logic [siq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [siq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int     ScaledW    = $clog2(((1 << siq_pkg::ADC_W) - 1) * FILTER_SCALE + 1);
    localparam int     LevelShift = siq_pkg::ACC_W + $clog2(FILTER_SCALE);
    localparam longint LevelRecip = ((longint'(1) << LevelShift) + FILTER_SCALE - 1)
                                    / FILTER_SCALE;
    localparam int     LevelRW    = $clog2(LevelRecip + 1);
    localparam int     LevelPW    = siq_pkg::ACC_W + LevelRW;

    siq_pkg::cfg_t           cfg;
    logic [ScaledW-1:0]      thr_scaled;
    logic [ScaledW-1:0]      hys_scaled;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    siq_pkg::sample_t        in_sample_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    siq_pkg::result_t        out_result_reg;
    siq_pkg::result_t        result_next;
    logic                    s_take;
    logic                    advance;
    logic [LevelPW-1:0]      level_product;

    siq_cfg_regs #(
        .FILTER_SCALE (FILTER_SCALE),
        .SCALED_W     (ScaledW)
    ) u_cfg_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .thr_scaled (thr_scaled),
        .hys_scaled (hys_scaled)
    );

    siq_qualify #(
        .FILTER_TIME  (FILTER_TIME),
        .FILTER_SCALE (FILTER_SCALE),
        .SCALED_W     (ScaledW)
    ) u_qualify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .sample      (in_sample_reg),
        .cfg         (cfg),
        .thr_scaled  (thr_scaled),
        .hys_scaled  (hys_scaled),
        .result_next (result_next)
    );

    // A held beat moves on whenever the result register is empty or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_sample_reg.pin_level  <= s_pin_level;
            in_sample_reg.adc_sample <= s_adc_sample;
            in_sample_reg.now_ms     <= s_now_ms;
        end
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    // Level is the accumulator over the scale, done as an exact reciprocal multiply.
    assign level_product    = LevelPW'(out_result_reg.filter_accum) * LevelPW'(LevelRecip);
    assign m_filtered_level = siq_pkg::LEVEL_W'(level_product >> LevelShift);

    assign m_valid        = out_valid_reg;
    assign m_raw_value    = out_result_reg.raw_value;
    assign m_stable_value = out_result_reg.stable_value;
    assign m_edge_event   = out_result_reg.edge_event;

    a_edge_matches_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.edge_event != siq_pkg::EDGE_NONE)
        |-> out_result_reg.stable_value == out_result_reg.raw_value)
        else $error("edge reported while stable and raw values differ");

    a_edge_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.edge_event == siq_pkg::EDGE_RISE)
        |-> out_result_reg.raw_value != '0)
        else $error("rising edge reported for a zero value");

    a_fall_to_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.edge_event == siq_pkg::EDGE_FALL)
        |-> out_result_reg.raw_value == '0)
        else $error("falling edge reported for a nonzero value");

    a_held_beat_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_sample_reg))
        else $error("input beat dropped before it was processed");

endmodule

// ===== tb/sensor_input_qualifier_top_tb.sv =====
// Self-checking testbench for the sensor input qualifier: predicted results against the DUT.
module sensor_input_qualifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [siq_pkg::VAL_W-1:0]   raw;
        logic [siq_pkg::VAL_W-1:0]   stable;
        siq_pkg::edge_t              edge_ev;
        logic [siq_pkg::LEVEL_W-1:0] level;
    } qual_out_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_pin_level;
    logic [siq_pkg::ADC_W-1:0]       s_adc_sample;
    logic [siq_pkg::TIME_W-1:0]      s_now_ms;
    logic                            m_valid;
    logic                            m_ready;
    logic [siq_pkg::VAL_W-1:0]       m_raw_value;
    logic [siq_pkg::VAL_W-1:0]       m_stable_value;
    logic [siq_pkg::EDGE_W-1:0]      m_edge_event;
    logic [siq_pkg::LEVEL_W-1:0]     m_filtered_level;
    logic                            cfg_wr_en;
    logic [siq_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [siq_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Predictor copy of the configuration and of the running state.
    siq_pkg::cfg_t                   active_cfg;
    logic [siq_pkg::ACC_W-1:0]       filt_acc_q;
    logic [siq_pkg::VAL_W-1:0]       prev_raw_q;
    logic [siq_pkg::VAL_W-1:0]       accepted_q;
    logic [siq_pkg::TIME_W-1:0]      last_change_q;

    siq_pkg::sample_t                queued_samples[$];
    qual_out_t                       predicted_quals[$];
    siq_pkg::sample_t                next_sample;
    qual_out_t                       front_qual;
    int unsigned                     beats_sent;
    int unsigned                     beats_taken;
    int unsigned                     send_gap;
    int unsigned                     stall_left;
    int unsigned                     fail_count;
    bit                              steady_traffic;
    logic [siq_pkg::TIME_W-1:0]      ms_clock;

    sensor_input_qualifier_top i_dut (.*);

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_traffic || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic qual_out_t qualify_sample(logic pin, logic [siq_pkg::ADC_W-1:0] adc,
                                                 logic [siq_pkg::TIME_W-1:0] now);
        siq_pkg::mode_t             mode;
        logic [siq_pkg::VAL_W-1:0]  val;
        siq_pkg::edge_t             ev;
        logic [63:0]                acc_next;
        int unsigned                lvl;
        int unsigned                lower;
        int unsigned                rungs;
        bit                         below_zero;
        logic [siq_pkg::TIME_W-1:0] hold_end;
        qual_out_t                  r;
        mode = (active_cfg.mode_override != siq_pkg::MODE_DEFAULT) ?
               active_cfg.mode_override : active_cfg.mode_normal;
        val = '0;
        ev = siq_pkg::EDGE_NONE;
        below_zero = active_cfg.hysteresis > active_cfg.threshold;
        lower = below_zero ? 0 : active_cfg.threshold - active_cfg.hysteresis;
        if (mode == siq_pkg::MODE_FORCE_ON) begin
            val = 3'd1;
        end else if (mode == siq_pkg::MODE_FORCE_OFF) begin
            val = 3'd0;
        end else if (!active_cfg.analog_enable) begin
            val = {2'b00, pin ^ (mode == siq_pkg::MODE_ACTIVE_LOW
                                 || mode == siq_pkg::MODE_LOW_PULLUP)};
        end else begin
            acc_next = (64'(filt_acc_q) * 64'(siq_pkg::FILTER_TIME_DEF - 1)
                        + 64'(adc) * 64'(siq_pkg::FILTER_SCALE_DEF)
                        + 64'(siq_pkg::FILTER_SCALE_DEF / 2))
                       / 64'(siq_pkg::FILTER_TIME_DEF);
            filt_acc_q = acc_next[siq_pkg::ACC_W-1:0];
            lvl = filt_acc_q / siq_pkg::FILTER_SCALE_DEF;
            case (mode)
                siq_pkg::MODE_ACTIVE_LOW: begin
                    if (prev_raw_q != 0) val = 3'(lvl < active_cfg.threshold);
                    else val = below_zero ? 3'd1 : 3'(lvl < lower);
                end
                siq_pkg::MODE_ACTIVE_HIGH: begin
                    if (prev_raw_q != 0) val = below_zero ? 3'd0 : 3'(lvl >= lower);
                    else val = 3'(lvl >= active_cfg.threshold);
                end
                siq_pkg::MODE_LADDER: begin
                    rungs = (active_cfg.ladder_count > siq_pkg::LADDER_MAX) ?
                            siq_pkg::LADDER_MAX : active_cfg.ladder_count;
                    // Walking down from the top leaves the lowest matching rung in val.
                    for (int k = rungs; k >= 1; k--) begin
                        if (adc < active_cfg.ladder_levels[siq_pkg::ADC_W*(k-1) +:
                                                           siq_pkg::ADC_W]) begin
                            val = 3'(k);
                        end
                    end
                end
                default: val = 3'd0;
            endcase
        end

        hold_end = last_change_q + 32'(active_cfg.debounce_ms);
        if (val != prev_raw_q) begin
            prev_raw_q = val;
            last_change_q = now;
        end else if (hold_end < now && accepted_q != val) begin
            ev = (val != 0) ? siq_pkg::EDGE_RISE : siq_pkg::EDGE_FALL;
            accepted_q = val;
        end

        r.raw = val;
        r.stable = accepted_q;
        r.edge_ev = ev;
        r.level = 10'(filt_acc_q / siq_pkg::FILTER_SCALE_DEF);
        return r;
    endfunction

    task automatic check_field(string field, logic [9:0] want, logic [9:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Input side: one beat per accepted handshake, payload held until then.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (beats_taken == beats_sent) begin
            if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (queued_samples.size() != 0) begin
                next_sample = queued_samples.pop_front();
                s_valid <= 1'b1;
                s_pin_level <= next_sample.pin_level;
                s_adc_sample <= next_sample.adc_sample;
                s_now_ms <= next_sample.now_ms;
                beats_sent <= beats_sent + 1;
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady_traffic && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Results are checked before this edge's input beat is predicted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_quals.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual raw %0d stable %0d",
                             $time, m_raw_value, m_stable_value);
                    fail_count++;
                end else begin
                    front_qual = predicted_quals.pop_front();
                    check_field("raw_value", 10'(front_qual.raw), 10'(m_raw_value));
                    check_field("stable_value", 10'(front_qual.stable), 10'(m_stable_value));
                    check_field("edge_event", 10'(front_qual.edge_ev), 10'(m_edge_event));
                    check_field("filtered_level", front_qual.level, m_filtered_level);
                end
            end
            if (s_valid && s_ready) begin
                predicted_quals.push_back(qualify_sample(s_pin_level, s_adc_sample, s_now_ms));
                beats_taken <= beats_taken + 1;
            end
        end
    end

    task automatic add_sample(logic pin, logic [siq_pkg::ADC_W-1:0] adc,
                              logic [siq_pkg::TIME_W-1:0] now);
        siq_pkg::sample_t smp;
        smp.pin_level = pin;
        smp.adc_sample = adc;
        smp.now_ms = now;
        queued_samples.push_back(smp);
    endtask

    task automatic wait_drained();
        while (queued_samples.size() != 0 || beats_taken != beats_sent
               || predicted_quals.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(siq_pkg::cfg_reg_t idx, logic [siq_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic apply_settings(siq_pkg::cfg_t c);
        write_reg(siq_pkg::CFG_MODE_NORMAL, siq_pkg::CFG_DATA_W'(c.mode_normal));
        write_reg(siq_pkg::CFG_MODE_OVERRIDE, siq_pkg::CFG_DATA_W'(c.mode_override));
        write_reg(siq_pkg::CFG_ANALOG_ENABLE, siq_pkg::CFG_DATA_W'(c.analog_enable));
        write_reg(siq_pkg::CFG_THRESHOLD, siq_pkg::CFG_DATA_W'(c.threshold));
        write_reg(siq_pkg::CFG_HYSTERESIS, siq_pkg::CFG_DATA_W'(c.hysteresis));
        write_reg(siq_pkg::CFG_DEBOUNCE_MS, siq_pkg::CFG_DATA_W'(c.debounce_ms));
        write_reg(siq_pkg::CFG_LADDER_COUNT, siq_pkg::CFG_DATA_W'(c.ladder_count));
        write_reg(siq_pkg::CFG_LADDER_LEVELS, c.ladder_levels);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active_cfg = c;
    endtask

    function automatic logic [siq_pkg::ADC_W-1:0] pick_ten_bit();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return siq_pkg::ADC_W'($urandom_range(0, 1023));
    endfunction

    function automatic siq_pkg::cfg_t random_settings(int unsigned phase);
        siq_pkg::cfg_t c;
        int unsigned   bound;
        int unsigned   roll;
        c.mode_normal = (phase < 8) ? siq_pkg::mode_t'(phase)
                                    : siq_pkg::mode_t'($urandom_range(0, 7));
        c.mode_override = (phase < 8 || $urandom_range(0, 1) == 0) ?
                          siq_pkg::MODE_DEFAULT : siq_pkg::mode_t'($urandom_range(0, 7));
        c.analog_enable = ($urandom_range(0, 9) < 7);
        c.threshold = pick_ten_bit();
        c.hysteresis = ($urandom_range(0, 3) == 0) ? pick_ten_bit()
                                                   : siq_pkg::ADC_W'($urandom_range(0, 150));
        roll = $urandom_range(0, 9);
        c.debounce_ms = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 40));
        c.ladder_count = siq_pkg::VAL_W'($urandom_range(0, 7));
        bound = 0;
        for (int k = 0; k < siq_pkg::LADDER_SLOTS; k++) begin
            bound += $urandom_range(0, 220);
            if (bound > 1023) bound = 1023;
            c.ladder_levels[siq_pkg::ADC_W*k +: siq_pkg::ADC_W] = siq_pkg::ADC_W'(bound);
        end
        // Now and then the bounds are not ascending at all.
        roll = $urandom_range(0, 9);
        if (roll == 0) c.ladder_levels = '1;
        else if (roll == 1) c.ladder_levels = siq_pkg::CFG_DATA_W'({$urandom, $urandom});
        return c;
    endfunction

    // Runs of steady pin level and converter level, with glitches and time jumps.
    task automatic queue_random_samples(int unsigned count,
                                        logic [siq_pkg::DEB_W-1:0] hold_ms);
        int unsigned run_left;
        int unsigned step_max;
        int unsigned roll;
        int          level_target;
        int          adc;
        logic        pin;
        logic        glitch;
        run_left = 0;
        pin = 1'b0;
        level_target = 512;
        step_max = hold_ms / 8 + 4;
        for (int unsigned n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 24);
                pin = 1'($urandom_range(0, 1));
                roll = $urandom_range(0, 9);
                level_target = (roll == 0) ? 0 : (roll == 1) ? 1023 : $urandom_range(0, 1023);
            end
            run_left--;
            adc = level_target + int'($urandom_range(0, 32)) - 16;
            if (adc < 0) adc = 0;
            if (adc > 1023) adc = 1023;
            glitch = ($urandom_range(0, 19) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                ms_clock = ms_clock;
            end else if (roll < 92) begin
                ms_clock += $urandom_range(1, step_max);
            end else if (roll < 97) begin
                ms_clock += $urandom_range(step_max, 400);
            end else if (roll < 99) begin
                ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
            end else begin
                ms_clock = $urandom;
            end
            add_sample(pin ^ glitch, siq_pkg::ADC_W'(adc), ms_clock);
        end
    endtask

    initial begin
        siq_pkg::cfg_t phase_cfg;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pin_level = 1'b0;
        s_adc_sample = '0;
        s_now_ms = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = siq_pkg::CFG_MODE_NORMAL;
        cfg_wdata = '0;
        beats_sent = 0;
        beats_taken = 0;
        send_gap = 0;
        stall_left = 0;
        fail_count = 0;
        steady_traffic = 1'b0;
        ms_clock = '0;
        active_cfg.mode_normal = siq_pkg::MODE_DEFAULT;
        active_cfg.mode_override = siq_pkg::MODE_DEFAULT;
        active_cfg.analog_enable = 1'b0;
        active_cfg.threshold = siq_pkg::THRESHOLD_RST;
        active_cfg.hysteresis = '0;
        active_cfg.debounce_ms = siq_pkg::DEBOUNCE_RST;
        active_cfg.ladder_count = '0;
        active_cfg.ladder_levels = '0;
        filt_acc_q = '0;
        prev_raw_q = '0;
        accepted_q = '0;
        last_change_q = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings, digital pin: rise after the hold time, then a fall whose
        // hold end wraps past the top of the millisecond counter.
        add_sample(1'b1, 10'd1023, 32'd10);
        add_sample(1'b1, 10'd0, 32'd30);
        add_sample(1'b1, 10'd1023, 32'd36);
        add_sample(1'b0, 10'd0, 32'hFFFF_FFF0);
        add_sample(1'b0, 10'd0, 32'hFFFF_FFFF);
        add_sample(1'b0, 10'h2AA, 32'd0);
        wait_drained();

        // Analog active low with hysteresis above the threshold.
        phase_cfg = active_cfg;
        phase_cfg.analog_enable = 1'b1;
        phase_cfg.mode_normal = siq_pkg::MODE_ACTIVE_LOW;
        phase_cfg.threshold = 10'd100;
        phase_cfg.hysteresis = 10'd1023;
        phase_cfg.debounce_ms = 8'd0;
        apply_settings(phase_cfg);
        add_sample(1'b0, 10'd1023, 32'd100);
        add_sample(1'b1, 10'd1023, 32'd101);
        add_sample(1'b0, 10'd0, 32'd102);
        add_sample(1'b1, 10'd0, 32'd103);
        wait_drained();

        phase_cfg.mode_override = siq_pkg::MODE_ACTIVE_HIGH;
        apply_settings(phase_cfg);
        add_sample(1'b0, 10'd1023, 32'd110);
        add_sample(1'b0, 10'd1023, 32'd111);
        add_sample(1'b0, 10'd0, 32'd112);
        wait_drained();

        // Ladder with a rung count above the maximum.
        phase_cfg.mode_override = siq_pkg::MODE_LADDER;
        phase_cfg.ladder_count = 3'd7;
        phase_cfg.ladder_levels = {10'd1023, 10'd500, 10'd400, 10'd300, 10'd200, 10'd100};
        apply_settings(phase_cfg);
        add_sample(1'b0, 10'd0, 32'd120);
        add_sample(1'b0, 10'd1023, 32'd121);
        add_sample(1'b0, 10'd450, 32'd122);
        add_sample(1'b0, 10'd1022, 32'd123);
        wait_drained();

        phase_cfg.mode_override = siq_pkg::MODE_FORCE_ON;
        apply_settings(phase_cfg);
        add_sample(1'b0, 10'd0, 32'd130);
        add_sample(1'b0, 10'd0, 32'd140);
        wait_drained();

        phase_cfg.mode_override = siq_pkg::MODE_FORCE_OFF;
        apply_settings(phase_cfg);
        add_sample(1'b1, 10'd1023, 32'd150);
        add_sample(1'b1, 10'd1023, 32'd160);
        wait_drained();

        // Pullup modes mean nothing on the converter path.
        phase_cfg.mode_override = siq_pkg::MODE_LOW_PULLUP;
        apply_settings(phase_cfg);
        add_sample(1'b1, 10'd1023, 32'd170);
        add_sample(1'b0, 10'd0, 32'd180);
        wait_drained();

        ms_clock = 32'd200;
        for (int unsigned phase = 0; phase < 14; phase++) begin
            phase_cfg = random_settings(phase);
            if (phase == 0) begin
                phase_cfg.threshold = '0;
                phase_cfg.hysteresis = '1;
                phase_cfg.debounce_ms = '1;
                phase_cfg.ladder_levels = '1;
            end else if (phase == 1) begin
                phase_cfg.threshold = '1;
                phase_cfg.hysteresis = '0;
                phase_cfg.debounce_ms = '0;
                phase_cfg.ladder_count = 3'd6;
                phase_cfg.ladder_levels = '0;
            end
            steady_traffic = (phase % 4 == 3);
            apply_settings(phase_cfg);
            queue_random_samples($urandom_range(52, 66), phase_cfg.debounce_ms);
            wait_drained();
        end

        steady_traffic = 1'b0;
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/siq_pkg.sv
rtl/siq_cfg_regs.sv
rtl/siq_filter.sv
rtl/siq_qualify.sv
rtl/sensor_input_qualifier_top.sv
tb/sensor_input_qualifier_top_tb.sv
